FILE: design/vfm_pkg.sv
// Shared types, constants and the face corner table of the voxel face mesher.
`default_nettype none
package vfm_pkg;

    localparam int CHUNK_SIDE   = 32;
    localparam int CORNER_SIDE  = CHUNK_SIDE + 1;
    localparam int CORNER_COUNT = CORNER_SIDE * CORNER_SIDE * CORNER_SIDE;
    localparam int ADDR_W       = $clog2(CORNER_COUNT);
    localparam int EPOCH_W      = 8;
    localparam int IDX_W        = 16;
    localparam int WORD_W       = EPOCH_W + IDX_W;
    localparam int POS_W        = 24;
    localparam int LOC_W        = 5;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    typedef struct packed {
        logic             first_in_chunk;
        logic [LOC_W-1:0] cube_x;
        logic [LOC_W-1:0] cube_y;
        logic [LOC_W-1:0] cube_z;
        logic             solid;
        logic             air_minus_z;
        logic             air_plus_y;
        logic             air_minus_y;
        logic             air_plus_z;
        logic             air_plus_x;
        logic             air_minus_x;
    } t_in;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] vertex_number;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
    } t_origin;

    // Corner code: bit 0 is +x, bit 1 is +y, bit 2 is +z.
    function automatic logic [2:0] corner_code(input logic [2:0] face, input logic [2:0] slot);
        logic [17:0] row;
        row = 18'd0;
        unique case (face)
            3'd0:    row = {3'd3, 3'd1, 3'd0, 3'd2, 3'd3, 3'd0};
            3'd1:    row = {3'd7, 3'd3, 3'd2, 3'd6, 3'd7, 3'd2};
            3'd2:    row = {3'd4, 3'd5, 3'd0, 3'd5, 3'd1, 3'd0};
            3'd3:    row = {3'd7, 3'd6, 3'd4, 3'd5, 3'd7, 3'd4};
            3'd4:    row = {3'd3, 3'd7, 3'd1, 3'd7, 3'd5, 3'd1};
            3'd5:    row = {3'd6, 3'd2, 3'd0, 3'd4, 3'd6, 3'd0};
            default: row = 18'd0;
        endcase
        return row[slot*3 +: 3];
    endfunction

endpackage
`default_nettype wire

FILE: design/vfm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module vfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/vfm_engine.sv
// Face sequencer: corner map lookups and inserts, vertex and index emission.
`default_nettype none
module vfm_engine
    import vfm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_item_valid,
    input  wire t_in     i_item,
    output logic         o_take,
    input  wire t_origin i_origin,
    output logic         o_res_valid,
    output t_out         o_res,
    input  wire logic    i_res_free
);

    typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_FACE, S_LOOK, S_RESP, S_TRI} t_state;

    t_state               r_state;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_resume;
    logic [EPOCH_W-1:0]   r_cur;
    logic [IDX_W-1:0]     r_count;
    logic [LOC_W-1:0]     r_cx, r_cy, r_cz;
    logic [5:0]           r_vis;
    logic [2:0]           r_face;
    logic                 r_last_face;
    logic [2:0]           r_slot;
    logic [IDX_W-1:0]     r_idx [6];

    logic [2:0]           code;
    logic [ADDR_W-1:0]    look_addr;
    logic [WORD_W-1:0]    rdata;
    logic                 hit;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [5:0]           vis_in;
    logic                 in_range;
    logic [5:0]           low_bit;
    logic [POS_W:0]       sum_x, sum_y, sum_z;

    assign code = corner_code(r_face, r_slot);

    always_comb begin
        look_addr = (ADDR_W'({1'b0, r_cz} + LOC_W'(code[2])) * ADDR_W'(CORNER_SIDE)
                     + ADDR_W'({1'b0, r_cy} + LOC_W'(code[1]))) * ADDR_W'(CORNER_SIDE)
                    + ADDR_W'({1'b0, r_cx} + LOC_W'(code[0]));
    end

    assign hit = (rdata[WORD_W-1 -: EPOCH_W] == r_cur);

    assign sum_x = {1'b0, i_origin.x} + (POS_W+1)'(r_cx) + (POS_W+1)'(code[0]);
    assign sum_y = {1'b0, i_origin.y} + (POS_W+1)'(r_cy) + (POS_W+1)'(code[1]);
    assign sum_z = {1'b0, i_origin.z} + (POS_W+1)'(r_cz) + (POS_W+1)'(code[2]);

    always_comb begin
        in_range = (32'(i_item.cube_x) < CHUNK_SIDE) && (32'(i_item.cube_y) < CHUNK_SIDE)
                   && (32'(i_item.cube_z) < CHUNK_SIDE);
        vis_in[0] = i_item.air_minus_z && ((i_origin.z != '0) || (i_item.cube_z != '0));
        vis_in[1] = i_item.air_plus_y;
        vis_in[2] = i_item.air_minus_y && ((i_origin.y != '0) || (i_item.cube_y != '0));
        vis_in[3] = i_item.air_plus_z;
        vis_in[4] = i_item.air_plus_x;
        vis_in[5] = i_item.air_minus_x && ((i_origin.x != '0) || (i_item.cube_x != '0));
        if (!(i_item.solid && in_range)) begin
            vis_in = 6'd0;
        end
    end

    assign low_bit = r_vis & (~r_vis + 6'd1);
    assign o_take  = (r_state == S_IDLE) && i_item_valid;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = look_addr;
        ram_wdata = {r_cur, r_count};
        if (r_state == S_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = '0;
        end else if (r_state == S_RESP && !hit && i_res_free) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        o_res_valid       = 1'b0;
        o_res             = '0;
        if (r_state == S_RESP && !hit) begin
            o_res_valid         = 1'b1;
            o_res.kind          = KIND_VERTEX;
            o_res.vertex_number = r_count;
            o_res.pos_x         = sum_x[POS_W] ? '1 : sum_x[POS_W-1:0];
            o_res.pos_y         = sum_y[POS_W] ? '1 : sum_y[POS_W-1:0];
            o_res.pos_z         = sum_z[POS_W] ? '1 : sum_z[POS_W-1:0];
        end else if (r_state == S_TRI) begin
            o_res_valid         = 1'b1;
            o_res.kind          = KIND_INDEX;
            o_res.vertex_number = r_idx[r_slot];
            o_res.last          = r_last_face && (r_slot == 3'd5);
        end
    end

    vfm_ram #(.WIDTH(WORD_W), .DEPTH(CORNER_COUNT)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_LOOK),
        .i_raddr (look_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_addr   <= '0;
            r_resume <= 1'b0;
            r_cur    <= '0;
            r_count  <= '0;
            r_vis    <= '0;
        end else begin
            unique case (r_state)
                S_SWEEP: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    if (r_addr == ADDR_W'(CORNER_COUNT - 1)) begin
                        r_addr  <= '0;
                        r_cur   <= EPOCH_W'(1);
                        r_state <= r_resume ? S_FACE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_cx  <= i_item.cube_x;
                        r_cy  <= i_item.cube_y;
                        r_cz  <= i_item.cube_z;
                        r_vis <= vis_in;
                        r_state <= S_FACE;
                        if (i_item.first_in_chunk) begin
                            r_count <= '0;
                            // Epochs are exhausted: wipe the map, then start over at one.
                            if (r_cur == '1) begin
                                r_resume <= 1'b1;
                                r_state  <= S_SWEEP;
                            end else begin
                                r_cur <= r_cur + EPOCH_W'(1);
                            end
                        end
                    end
                end
                S_FACE: begin
                    if (r_vis == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        for (int k = 0; k < 6; k++) begin
                            if (low_bit[k]) begin
                                r_face <= 3'(k);
                            end
                        end
                        r_vis       <= r_vis & ~low_bit;
                        r_last_face <= (r_vis & ~low_bit) == '0;
                        r_slot      <= 3'd0;
                        r_state     <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (hit || i_res_free) begin
                        if (hit) begin
                            r_idx[r_slot] <= rdata[IDX_W-1:0];
                        end else begin
                            r_idx[r_slot] <= r_count;
                            r_count       <= r_count + IDX_W'(1);
                        end
                        if (r_slot == 3'd5) begin
                            r_slot  <= 3'd0;
                            r_state <= S_TRI;
                        end else begin
                            r_slot  <= r_slot + 3'd1;
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_TRI: begin
                    if (i_res_free) begin
                        if (r_slot == 3'd5) begin
                            r_state <= S_FACE;
                        end else begin
                            r_slot <= r_slot + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && !hit && i_res_free) |=> (r_count == $past(r_count) + IDX_W'(1)))
        else $error("vertex counter did not advance on insert");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> (r_state == S_TRI && r_slot == 3'd5 && r_vis == '0))
        else $error("last flag raised before the final index");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_state == S_IDLE))
        else $error("item taken while busy");
    a_sweep_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (ram_we && ram_wdata == '0))
        else $error("clearing pass failed to write");
`endif

endmodule
`default_nettype wire

FILE: design/voxel_face_mesher_unit.sv
// Top level of the voxel face mesher: channel registers, origin registers and the engine.
`default_nettype none
// Each solid voxel is turned into vertex and triangle index transactions for its visible
// faces. For each face the engine picks the face, then makes six corner lookups, each an
// address step and a response step, because corner map read data is registered; then it
// emits six index transactions. A stalled output holds vertex and index emission.
// The corner map holds an epoch tag per entry; after reset, and once every 255 chunks,
// a clearing pass writes all 35937 map entries while no voxel is processed.
// Origin registers are written through the configuration port, index 0 to 2 for x, y, z.
module voxel_face_mesher_unit
    import vfm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [POS_W-1:0]     i_cfg_data
);

    logic    r_in_valid;
    t_in     r_in;
    logic    r_out_valid;
    t_out    r_out;
    t_origin r_origin;
    logic    take;
    logic    res_valid;
    t_out    res;
    logic    res_free;

    assign o_in_stall  = r_in_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign res_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_origin    <= '0;
        end else begin
            if (i_in_valid && !r_in_valid) begin
                r_in_valid <= 1'b1;
                r_in       <= i_in_data;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (res_valid && res_free) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ORIGIN_X: r_origin.x <= i_cfg_data;
                    CFG_ORIGIN_Y: r_origin.y <= i_cfg_data;
                    CFG_ORIGIN_Z: r_origin.z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    vfm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .o_take       (take),
        .i_origin     (r_origin),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_free   (res_free)
    );

endmodule
`default_nettype wire

FILE: tb/voxel_face_mesher_unit_test.sv
// Self-checking testbench of the voxel face mesher: random and directed voxels, scoreboard check.
`default_nettype none
module voxel_face_mesher_unit_test;
    import vfm_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 150000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [POS_W-1:0] ORIGIN_HIGH = 24'd16777151;

    class mesh_scoreboard;
        bit               corner_seen [CORNER_COUNT];
        logic [IDX_W-1:0] corner_number [CORNER_COUNT];
        logic [IDX_W-1:0] next_vertex;
        int unsigned      org [3];
        t_out             mesh_queue [$];
        int               fail_count;
        int               face_corner [6][6] = '{
            '{0, 3, 2, 0, 1, 3}, '{2, 7, 6, 2, 3, 7}, '{0, 1, 5, 0, 5, 4},
            '{4, 7, 5, 4, 6, 7}, '{1, 5, 7, 1, 7, 3}, '{0, 6, 4, 0, 2, 6}};

        function new();
            foreach (corner_seen[i]) corner_seen[i] = 1'b0;
            next_vertex = '0;
            org = '{0, 0, 0};
            fail_count = 0;
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            fail_count++;
        endfunction

        function int pending();
            return mesh_queue.size();
        endfunction

        function void set_origin(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] value);
            case (idx)
                CFG_ORIGIN_X: org[0] = value;
                CFG_ORIGIN_Y: org[1] = value;
                CFG_ORIGIN_Z: org[2] = value;
                default: ;
            endcase
        endfunction

        function logic [POS_W-1:0] clamp(int unsigned v);
            return (v > 32'hFFFFFF) ? 24'hFFFFFF : v[POS_W-1:0];
        endfunction

        // Works out every transaction a voxel produces and queues them in order.
        function void note_voxel(t_in v);
            bit          visible [6];
            int unsigned slot [6];
            int unsigned cx, cy, cz, s, c, dx, dy, dz;
            t_out        r;
            t_out        batch [$];
            if (v.first_in_chunk) begin
                foreach (corner_seen[i]) corner_seen[i] = 1'b0;
                next_vertex = '0;
            end
            if (!v.solid) return;
            cx = v.cube_x;
            cy = v.cube_y;
            cz = v.cube_z;
            if (cx >= CHUNK_SIDE || cy >= CHUNK_SIDE || cz >= CHUNK_SIDE) return;
            visible[0] = v.air_minus_z && (org[2] + cz > 0);
            visible[1] = v.air_plus_y;
            visible[2] = v.air_minus_y && (org[1] + cy > 0);
            visible[3] = v.air_plus_z;
            visible[4] = v.air_plus_x;
            visible[5] = v.air_minus_x && (org[0] + cx > 0);
            for (int f = 0; f < 6; f++) begin
                if (!visible[f]) continue;
                for (int i = 0; i < 6; i++) begin
                    c = face_corner[f][i];
                    dx = c & 1;
                    dy = (c >> 1) & 1;
                    dz = (c >> 2) & 1;
                    s = ((cz + dz) * CORNER_SIDE + (cy + dy)) * CORNER_SIDE + (cx + dx);
                    slot[i] = s;
                    if (!corner_seen[s]) begin
                        corner_seen[s] = 1'b1;
                        corner_number[s] = next_vertex;
                        r.kind = KIND_VERTEX;
                        r.vertex_number = next_vertex;
                        r.pos_x = clamp(org[0] + cx + dx);
                        r.pos_y = clamp(org[1] + cy + dy);
                        r.pos_z = clamp(org[2] + cz + dz);
                        r.last = 1'b0;
                        batch = {batch, r};
                        next_vertex = next_vertex + 1'b1;
                    end
                end
                for (int i = 0; i < 6; i++) begin
                    r.kind = KIND_INDEX;
                    r.vertex_number = corner_number[slot[i]];
                    r.pos_x = '0;
                    r.pos_y = '0;
                    r.pos_z = '0;
                    r.last = 1'b0;
                    batch = {batch, r};
                end
            end
            if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
            mesh_queue = {mesh_queue, batch};
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (mesh_queue.size() == 0) begin
                report($sformatf("unexpected transaction %h", got));
                return;
            end
            want = mesh_queue.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %h, want %h", got.kind, want.kind));
            if (got.vertex_number !== want.vertex_number)
                report($sformatf("vertex_number %0d, want %0d",
                                 got.vertex_number, want.vertex_number));
            if (got.pos_x !== want.pos_x)
                report($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
            if (got.pos_y !== want.pos_y)
                report($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
            if (got.pos_z !== want.pos_z)
                report($sformatf("pos_z %0d, want %0d", got.pos_z, want.pos_z));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [POS_W-1:0]     i_cfg_data = '0;

    mesh_scoreboard sb = new();
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int quiet_cycles = 0;
    int unsigned base_x = 0, base_y = 0, base_z = 0;

    voxel_face_mesher_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // The clearing pass after reset stalls everything, so the limit is well above it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("voxel_face_mesher_unit_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in make_voxel(bit first, int x, int y, int z, bit solid,
                                       logic [5:0] air);
        return {first, x[4:0], y[4:0], z[4:0], solid, air};
    endfunction

    // Mostly clustered voxels in a chunk so corners are shared; some raw noise.
    function automatic t_in random_voxel();
        t_in v;
        if ($urandom_range(99) < 15) begin
            v = t_in'($bits(t_in)'($urandom));
        end else begin
            if ($urandom_range(29) == 0) begin
                base_x = ($urandom_range(3) == 0) ? 28 : $urandom_range(28);
                base_y = ($urandom_range(3) == 0) ? 0 : $urandom_range(28);
                base_z = $urandom_range(28);
                v.first_in_chunk = 1'b1;
            end else begin
                v.first_in_chunk = 1'b0;
            end
            v.cube_x = LOC_W'(base_x + $urandom_range(3));
            v.cube_y = LOC_W'(base_y + $urandom_range(3));
            v.cube_z = LOC_W'(base_z + $urandom_range(3));
            v.solid = ($urandom_range(99) < 85);
            {v.air_minus_z, v.air_plus_y, v.air_minus_y,
             v.air_plus_z, v.air_plus_x, v.air_minus_x} = 6'($urandom);
        end
        return v;
    endfunction

    task automatic send_voxel(t_in v);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= v;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_voxel(v);
    endtask

    // Lowers valid and waits until every queued transaction has come back.
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_origin(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_origin(idx, value);
    endtask

    task automatic set_origins(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                               logic [POS_W-1:0] z);
        write_origin(CFG_ORIGIN_X, x);
        write_origin(CFG_ORIGIN_Y, y);
        write_origin(CFG_ORIGIN_Z, z);
    endtask

    function automatic logic [POS_W-1:0] random_origin();
        case ($urandom_range(3))
            0: return '0;
            1: return ORIGIN_HIGH;
            default: return POS_W'($urandom_range(ORIGIN_HIGH));
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_origins('0, '0, '0);
        send_voxel(make_voxel(1, 0, 0, 0, 1, 6'h3F));
        send_voxel(make_voxel(0, 0, 0, 0, 1, 6'h3F));
        send_voxel(make_voxel(0, 31, 31, 31, 1, 6'h3F));
        send_voxel(make_voxel(0, 5, 5, 5, 0, 6'h3F));
        send_voxel(make_voxel(0, 5, 5, 5, 1, 6'h00));
        for (int i = 0; i < 6; i++) send_voxel(make_voxel(0, 10, 10, 10, 1, 6'(1 << i)));
        send_voxel(make_voxel(1, 1, 1, 1, 1, 6'h3F));
        send_voxel(make_voxel(1, 2, 2, 2, 0, 6'h3F));
        send_voxel(make_voxel(0, 3, 2, 2, 1, 6'h3F));
        drain_outputs();

        set_origins(ORIGIN_HIGH, ORIGIN_HIGH, ORIGIN_HIGH);
        send_voxel(make_voxel(1, 0, 0, 0, 1, 6'h3F));
        send_voxel(make_voxel(0, 31, 0, 31, 1, 6'h3F));
        send_voxel(make_voxel(0, 0, 31, 0, 1, 6'h3F));
        send_voxel(make_voxel(0, 31, 31, 31, 1, 6'h3F));
        drain_outputs();

        for (int phase = 0; phase < 3; phase++) begin
            in_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 52 : 0;
            out_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 34 : 0;
            set_origins(random_origin(), random_origin(), random_origin());
            for (int n = 0; n < 117; n++) begin
                if (phase == 1 && n == 57) drain_outputs();
                send_voxel(random_voxel());
            end
            drain_outputs();
        end

        if (sb.fail_count == 0) begin
            $display("voxel_face_mesher_unit_test OK");
        end else begin
            $display("voxel_face_mesher_unit_test NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
design/vfm_pkg.sv
design/vfm_ram.sv
design/vfm_engine.sv
design/voxel_face_mesher_unit.sv
tb/voxel_face_mesher_unit_test.sv
